>>> sv/sfrp_pkg.sv
// Shared types, constants and the check-byte function of the stuffed frame receiver.
package sfrp_pkg;

  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned PAYLOAD_CAP = 61;

  localparam logic [7:0] STUFF_OFFSET = 8'd2;

  localparam logic [7:0] START_FLAG_RST  = 8'hFF;
  localparam logic [7:0] END_FLAG_RST    = 8'hFE;
  localparam logic [7:0] ESCAPE_BYTE_RST = 8'hFD;
  localparam logic [5:0] MAX_PAYLOAD_RST = 6'd50;

  typedef enum logic [1:0] {
    REG_START_FLAG,
    REG_END_FLAG,
    REG_ESCAPE_BYTE,
    REG_MAX_PAYLOAD
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] start_flag;
    logic [7:0] end_flag;
    logic [7:0] escape_byte;
    logic [5:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic       accepted;
    logic [7:0] command;
    logic [5:0] payload_len;
    logic [7:0] payload_byte;
    logic [5:0] byte_index;
    logic       last;
  } result_t;

  // The substitution table is linear over GF(2): entry x is the XOR of one
  // column per set bit of x. Column k is the entry at index 2**k.
  localparam logic [7:0][7:0] HASH_COL = {
    8'hED, 8'h76, 8'h3B, 8'h1D, 8'h0E, 8'h07, 8'hEE, 8'h77
  };

  function automatic logic [7:0] pearson_lut(input logic [7:0] x);
    logic [7:0] h;
    h = '0;
    for (int k = 0; k < 8; k++) begin
      if (x[k]) begin
        h = h ^ HASH_COL[k];
      end
    end
    return h;
  endfunction

endpackage

>>> sv/sfrp_ram.sv
// Generic simple dual-port RAM with registered read data.
module sfrp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/sfrp_fsm.sv
// Frame sequencer: unstuffing, hashing, store writes, frame check and result readout.
module sfrp_fsm #(
  parameter int unsigned StoreDepth = sfrp_pkg::STORE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sfrp_pkg::cfg_t                cfg_i,
  input  logic                          in_valid_i,
  input  logic [7:0]                    in_byte_i,
  output logic                          in_ready_o,
  input  logic                          res_ready_i,
  output logic                          res_valid_o,
  output sfrp_pkg::result_t             res_o,
  output logic                          ram_we_o,
  output logic [$clog2(StoreDepth)-1:0] ram_waddr_o,
  output logic [7:0]                    ram_wdata_o,
  output logic [$clog2(StoreDepth)-1:0] ram_raddr_o,
  input  logic [7:0]                    ram_rdata_i
);

  localparam int unsigned AddrW = $clog2(StoreDepth);
  localparam int unsigned CntW  = $clog2(StoreDepth + 1);
  localparam int unsigned CmpW  = ((CntW > 8) ? CntW : 8) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_LEN,
    S_CHECK,
    S_CMD,
    S_EM_RD,
    S_EM_OUT,
    S_SINGLE
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              open_q, open_d;
  logic              esc_q, esc_d;
  logic              ovf_q, ovf_d;
  logic [7:0]        hash_q, hash_d;
  logic [7:0]        hbl_q, hbl_d;
  logic [7:0]        last_q, last_d;
  logic              acc_q, acc_d;
  logic [7:0]        cmd_q, cmd_d;
  logic [5:0]        len_q, len_d;
  logic [5:0]        idx_q, idx_d;
  logic [AddrW-1:0]  eaddr_q, eaddr_d;

  logic       do_store;
  logic [7:0] store_val;
  logic [5:0] lim;
  logic       frame_ok;
  logic       em_last;
  logic       finish;

  assign lim = (cfg_i.max_payload > 6'(sfrp_pkg::PAYLOAD_CAP)) ?
               6'(sfrp_pkg::PAYLOAD_CAP) : cfg_i.max_payload;

  // length byte sits in ram_rdata_i during S_CHECK
  assign frame_ok = (hbl_q == last_q) &&
                    (CmpW'(ram_rdata_i) == (CmpW'(cnt_q) - CmpW'(3))) &&
                    (ram_rdata_i <= {2'b00, lim});

  assign em_last    = (idx_q == (len_q - 6'd1));
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    open_d      = open_q;
    esc_d       = esc_q;
    ovf_d       = ovf_q;
    hash_d      = hash_q;
    hbl_d       = hbl_q;
    last_d      = last_q;
    acc_d       = acc_q;
    cmd_d       = cmd_q;
    len_d       = len_q;
    idx_d       = idx_q;
    eaddr_d     = eaddr_q;
    do_store    = 1'b0;
    store_val   = in_byte_i;
    finish      = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = cnt_q[AddrW-1:0];
    ram_wdata_o = store_val;
    ram_raddr_o = eaddr_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          priority if (in_byte_i == cfg_i.start_flag) begin
            open_d = 1'b1;
            cnt_d  = '0;
            esc_d  = 1'b0;
            ovf_d  = 1'b0;
            hash_d = '0;
            hbl_d  = '0;
          end else if (in_byte_i == cfg_i.end_flag) begin
            esc_d  = 1'b0;
            open_d = 1'b0;
            if (!open_q || ovf_q || (cnt_q < CntW'(3))) begin
              acc_d   = 1'b0;
              state_d = S_SINGLE;
            end else begin
              state_d = S_RD_LEN;
            end
          end else if (open_q) begin
            if (esc_q) begin
              esc_d     = 1'b0;
              do_store  = 1'b1;
              store_val = in_byte_i + sfrp_pkg::STUFF_OFFSET;
            end else if (in_byte_i == cfg_i.escape_byte) begin
              esc_d = 1'b1;
            end else begin
              do_store = 1'b1;
            end
          end else begin
            // outside a frame: dropped
          end
        end
      end
      S_RD_LEN: begin
        ram_raddr_o = AddrW'(1);
        state_d     = S_CHECK;
      end
      S_CHECK: begin
        ram_raddr_o = '0;
        len_d       = ram_rdata_i[5:0];
        if (frame_ok) begin
          state_d = S_CMD;
        end else begin
          acc_d   = 1'b0;
          state_d = S_SINGLE;
        end
      end
      S_CMD: begin
        cmd_d   = ram_rdata_i;
        eaddr_d = AddrW'(2);
        idx_d   = '0;
        if (len_q == '0) begin
          acc_d   = 1'b1;
          state_d = S_SINGLE;
        end else begin
          state_d = S_EM_RD;
        end
      end
      S_EM_RD: begin
        state_d = S_EM_OUT;
      end
      S_EM_OUT: begin
        res_valid_o        = 1'b1;
        res_o.accepted     = 1'b1;
        res_o.command      = cmd_q;
        res_o.payload_len  = len_q;
        res_o.payload_byte = ram_rdata_i;
        res_o.byte_index   = idx_q;
        res_o.last         = em_last;
        if (res_ready_i) begin
          if (em_last) begin
            finish = 1'b1;
          end else begin
            idx_d   = idx_q + 6'd1;
            eaddr_d = eaddr_q + AddrW'(1);
            state_d = S_EM_RD;
          end
        end
      end
      S_SINGLE: begin
        res_valid_o    = 1'b1;
        res_o.accepted = acc_q;
        res_o.command  = acc_q ? cmd_q : 8'd0;
        res_o.last     = 1'b1;
        if (res_ready_i) begin
          finish = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    ram_wdata_o = store_val;

    if (do_store) begin
      if (cnt_q == CntW'(StoreDepth)) begin
        ovf_d = 1'b1;
      end else begin
        ram_we_o = 1'b1;
        cnt_d    = cnt_q + CntW'(1);
        hbl_d    = hash_q;
        hash_d   = sfrp_pkg::pearson_lut(hash_q ^ store_val);
        last_d   = store_val;
      end
    end

    if (finish) begin
      state_d = S_IDLE;
      cnt_d   = '0;
      ovf_d   = 1'b0;
      hash_d  = '0;
      hbl_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      open_q  <= 1'b0;
      esc_q   <= 1'b0;
      ovf_q   <= 1'b0;
      hash_q  <= '0;
      hbl_q   <= '0;
      acc_q   <= 1'b0;
      last_q  <= '0;
      cmd_q   <= '0;
      len_q   <= '0;
      idx_q   <= '0;
      eaddr_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      open_q  <= open_d;
      esc_q   <= esc_d;
      ovf_q   <= ovf_d;
      hash_q  <= hash_d;
      hbl_q   <= hbl_d;
      acc_q   <= acc_d;
      last_q  <= last_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      eaddr_q <= eaddr_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(StoreDepth))
    else $error("stored count beyond store depth");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (cnt_q == CntW'(StoreDepth)))
    else $error("overflow flagged with store not full");

  a_end_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_byte_i == cfg_i.end_flag) &&
     (in_byte_i != cfg_i.start_flag)) |=> !in_ready_o)
    else $error("byte taken while frame check pending");

  a_reject_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.accepted) |-> (res_o.last && (res_o.command == 8'd0)))
    else $error("reject result malformed");

endmodule

>>> sv/stuffed_frame_receiver_pearson_core.sv
// Top level of the byte-stuffed frame receiver with Pearson check byte.
// After the end flag an early reject goes straight to S_SINGLE; other frames pass S_RD_LEN,
//   S_CHECK (failed: S_SINGLE), S_CMD (empty payload: S_SINGLE), then S_EM_RD and S_EM_OUT.
// Throughput: 1 byte/cycle between flags; payload words leave one at a time, each after its own
//   store read, a reject or empty frame gives one word; input stalls meanwhile.
// Reset: rst_ni async active low clears control state and loads register defaults;
//   the frame store keeps no valid bits and is never cleared (only fresh entries are read).
module stuffed_frame_receiver_pearson_core #(
  parameter int unsigned StoreDepth = sfrp_pkg::STORE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // received byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] command, [13:8] payload_len,
                                      // [21:14] payload_byte, [27:22] byte_index, [31:28] 0
  output logic [0:0]  m_axis_tuser,   // [0] accepted
  output logic        m_axis_tlast,   // last word of the frame
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AddrW = $clog2(StoreDepth);

  // ---------------------------------------------------------------------------
  // Register file: start flag, end flag, escape byte, max payload at 4*i.
  // ---------------------------------------------------------------------------
  sfrp_pkg::cfg_t     cfg_q;
  sfrp_pkg::reg_idx_e reg_idx;
  logic               reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = sfrp_pkg::reg_idx_e'(paddr[3:2]);
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_flag  <= sfrp_pkg::START_FLAG_RST;
      cfg_q.end_flag    <= sfrp_pkg::END_FLAG_RST;
      cfg_q.escape_byte <= sfrp_pkg::ESCAPE_BYTE_RST;
      cfg_q.max_payload <= sfrp_pkg::MAX_PAYLOAD_RST;
    end else if (reg_wr) begin
      unique case (reg_idx)
        sfrp_pkg::REG_START_FLAG:  cfg_q.start_flag  <= pwdata[7:0];
        sfrp_pkg::REG_END_FLAG:    cfg_q.end_flag    <= pwdata[7:0];
        sfrp_pkg::REG_ESCAPE_BYTE: cfg_q.escape_byte <= pwdata[7:0];
        sfrp_pkg::REG_MAX_PAYLOAD: cfg_q.max_payload <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sfrp_pkg::REG_START_FLAG:  prdata = {24'd0, cfg_q.start_flag};
      sfrp_pkg::REG_END_FLAG:    prdata = {24'd0, cfg_q.end_flag};
      sfrp_pkg::REG_ESCAPE_BYTE: prdata = {24'd0, cfg_q.escape_byte};
      sfrp_pkg::REG_MAX_PAYLOAD: prdata = {26'd0, cfg_q.max_payload};
      default:                   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Frame store and sequencer. Between flags the sequencer writes at most one
  // unstuffed byte per cycle and after the end flag reads length, command, payload back.
  // ---------------------------------------------------------------------------
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [7:0]        ram_wdata;
  logic [AddrW-1:0]  ram_raddr;
  logic [7:0]        ram_rdata;

  logic              res_valid;
  logic              res_ready;
  sfrp_pkg::result_t res;

  sfrp_ram #(
    .Width (8),
    .Depth (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sfrp_fsm #(
    .StoreDepth (StoreDepth)
  ) u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_byte_i   (s_axis_tdata),
    .in_ready_o  (s_axis_tready),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Output register: holds one word so the sequencer can move on (and the
  // input side can take bytes) while the consumer stalls.
  // ---------------------------------------------------------------------------
  logic              out_valid_q;
  sfrp_pkg::result_t out_q;

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = {4'd0, out_q.byte_index, out_q.payload_byte,
                            out_q.payload_len, out_q.command};
  assign m_axis_tuser[0] = out_q.accepted;
  assign m_axis_tlast    = out_q.last;

endmodule
